[rtl/plf_pkg.sv]
// plf_pkg: shared types, codes and constants of the packet length framer.
// No dependencies.

package plf_pkg;

	typedef enum logic [3:0] {
		MODE_RAW      = 4'd0,
		MODE_ONE      = 4'd1,
		MODE_TWO      = 4'd2,
		MODE_FOUR     = 4'd3,
		MODE_RECMARK  = 4'd4,
		MODE_ASN1     = 4'd5,
		MODE_GIOP     = 4'd6,
		MODE_FCGI     = 4'd7,
		MODE_LINE     = 4'd8,
		MODE_HTTP     = 4'd9,
		MODE_HTTP_HDR = 4'd10,
		MODE_TPKT     = 4'd11,
		MODE_TLS      = 4'd12
	} mode_t;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_MAX   = 2'd1;
	localparam logic [1:0] REG_TRUNC = 2'd2;
	localparam logic [1:0] REG_DELIM = 2'd3;

	localparam logic [31:0] LEN_LIMIT = 32'h7fff_ffff;
	localparam int          HDR_DEPTH = 12;

	localparam logic [2:0] ASN_TAG      = 3'd0;
	localparam logic [2:0] ASN_LONG_TAG = 3'd1;
	localparam logic [2:0] ASN_LEN      = 3'd2;
	localparam logic [2:0] ASN_LONG_LEN = 3'd3;
	localparam logic [2:0] ASN_SKIP     = 3'd4;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] max_len;
		logic [31:0] cut_len;
		logic [7:0]  delim;
	} cfg_t;

	// scan state, updated on each accepted start byte and each accepted byte of an unfinished frame
	typedef struct packed {
		logic [31:0] count;
		logic [2:0]  asn_phase;
		logic [2:0]  asn_left;
		logic [31:0] acc;
		logic        hdr_mode;
		logic [31:0] pend;
		logic        done;
	} scan_t;

	// idle scan: waiting for a start byte
	localparam scan_t SCAN_IDLE = '{count: 32'd0, asn_phase: ASN_TAG, asn_left: 3'd0,
		acc: 32'd0, hdr_mode: 1'b0, pend: 32'd0, done: 1'b1};

	typedef struct packed {
		logic        emit;
		logic        err;
		logic [30:0] len;
	} res_t;

endpackage

[rtl/packet_length_framer.sv]
// packet_length_framer: top level; input register, scan core, result register.
// Depends on plf_pkg, plf_cfg, plf_core.
//
// channel  | valid    | stall     | payload
// input    | in_valid | in_stall  | data_byte, first_byte, in_headers
// result   | out_valid| out_stall | verdict, total_length
// config   | cfg_we   | -         | cfg_index, cfg_data
//
// One byte per clock while in_stall is low; an accepted byte is scanned from the input
// register and its verdict, if any, is then registered in the result register.
// Input stall only rises when the result register is full and stalled.
// Reset leaves the framer waiting for a start byte with config registers at defaults.

module packet_length_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        in_headers,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        verdict,
	output logic [30:0] total_length,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	plf_pkg::cfg_t cfg;
	plf_pkg::res_t res;
	logic       v_s1;
	logic [7:0] b_s1;
	logic       f_s1, h_s1;
	logic       adv;
	logic       ov_q, vd_q;
	logic [30:0] len_q;

	plf_cfg u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg
	);

	// stage 1 moves on unless the result register is full and stalled
	assign adv      = !(ov_q && out_stall);
	assign in_stall = !adv;

	plf_core u_core (
		.clk, .arst_n,
		.step(v_s1 && adv), .b(b_s1), .first(f_s1), .hdrs(h_s1),
		.cfg, .res
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			ov_q <= v_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1  <= data_byte;
			f_s1  <= first_byte;
			h_s1  <= in_headers;
			vd_q  <= res.err;
			len_q <= res.len;
		end
	end

	assign out_valid    = ov_q;
	assign verdict      = vd_q;
	assign total_length = len_q;

endmodule

[rtl/plf_cfg.sv]
// plf_cfg: configuration register file of the framer.
// Depends on plf_pkg.

module plf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output plf_pkg::cfg_t       cfg
);

	plf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= plf_pkg::MODE_RAW;
			cfg_q.max_len <= 32'd0;
			cfg_q.cut_len <= 32'd0;
			cfg_q.delim   <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				plf_pkg::REG_MODE:  cfg_q.mode    <= cfg_data[3:0];
				plf_pkg::REG_MAX:   cfg_q.max_len <= cfg_data;
				plf_pkg::REG_TRUNC: cfg_q.cut_len <= cfg_data;
				plf_pkg::REG_DELIM: cfg_q.delim   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/plf_core.sv]
// plf_core: per-byte scan state and verdict logic, one byte per cycle while step is high.
// Depends on plf_pkg.

module plf_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     b,
	input  logic           first,
	input  logic           hdrs,
	input  plf_pkg::cfg_t  cfg,
	output plf_pkg::res_t  res
);

	plf_pkg::scan_t st_q, st_d;
	logic [7:0] hb_q [plf_pkg::HDR_DEPTH];
	logic [7:0] h [plf_pkg::HDR_DEPTH];

	logic [31:0] n;
	logic        active;
	logic        e_err, e_len;
	logic [32:0] e_val;
	logic        pl_en;
	logic [31:0] pl_h, pl_p;
	logic [32:0] pl_sum;
	logic        pl_over;
	logic [31:0] lim, k32, p;
	logic        hdr_http;
	logic [6:0]  k;
	logic [15:0] v16;

	// header view including the byte of this cycle
	always_comb begin
		for (int i = 0; i < plf_pkg::HDR_DEPTH; i++)
			h[i] = (n == 32'(i + 1)) ? b : hb_q[i];
	end

	always_comb begin
		st_d    = st_q;
		e_err   = 1'b0;
		e_len   = 1'b0;
		e_val   = '0;
		pl_en   = 1'b0;
		pl_h    = '0;
		pl_p    = '0;
		k       = b[6:0];
		k32     = {25'd0, b[6:0]};
		p       = st_q.pend;
		v16     = {1'b0, h[0][6:0], h[1]};
		lim     = (cfg.max_len != 0) ? cfg.max_len : cfg.cut_len;
		hdr_http = (cfg.mode == plf_pkg::MODE_HTTP_HDR) || st_d.hdr_mode;
		if (first) begin
			st_d.count     = '0;
			st_d.asn_phase = plf_pkg::ASN_TAG;
			st_d.asn_left  = '0;
			st_d.acc       = '0;
			st_d.pend      = '0;
			st_d.hdr_mode  = hdrs;
			st_d.done      = 1'b0;
			p              = '0;
			hdr_http = (cfg.mode == plf_pkg::MODE_HTTP_HDR) || hdrs;
		end
		active = step && !st_d.done;
		if (st_d.count != 32'hffff_ffff)
			st_d.count = st_d.count + 32'd1;
		n = st_d.count;
		if (active) begin
			unique case (cfg.mode)
				plf_pkg::MODE_RAW: begin
					e_len = 1'b1; e_val = {1'b0, n};
				end
				plf_pkg::MODE_ONE: if (n == 1) begin
					pl_en = 1'b1; pl_h = 32'd1; pl_p = {24'd0, h[0]};
				end
				plf_pkg::MODE_TWO: if (n == 2) begin
					pl_en = 1'b1; pl_h = 32'd2; pl_p = {16'd0, h[0], h[1]};
				end
				plf_pkg::MODE_FOUR: if (n == 4) begin
					pl_en = 1'b1; pl_h = 32'd4; pl_p = {h[0], h[1], h[2], h[3]};
				end
				plf_pkg::MODE_RECMARK: if (n == 4) begin
					pl_en = 1'b1; pl_h = 32'd4; pl_p = {1'b0, h[0][6:0], h[1], h[2], h[3]};
				end
				plf_pkg::MODE_ASN1: begin
					priority case (st_q.asn_phase & {3{!first}})
						plf_pkg::ASN_TAG:
							st_d.asn_phase = (b[4:0] == 5'h1f) ? plf_pkg::ASN_LONG_TAG
								: plf_pkg::ASN_LEN;
						plf_pkg::ASN_LONG_TAG:
							if (!b[7]) st_d.asn_phase = plf_pkg::ASN_LEN;
						plf_pkg::ASN_LEN: begin
							if (!b[7] || k == 0) begin
								pl_en = 1'b1; pl_h = n; pl_p = k32;
							end else if (k <= 4) begin
								st_d.acc = '0; st_d.asn_left = k[2:0];
								st_d.asn_phase = plf_pkg::ASN_LONG_LEN;
							end else begin
								st_d.acc = k32; st_d.asn_left = '0;
								st_d.asn_phase = plf_pkg::ASN_SKIP;
							end
						end
						plf_pkg::ASN_LONG_LEN: begin
							st_d.acc = {st_q.acc[23:0], b};
							st_d.asn_left = st_q.asn_left - 3'd1;
							if (st_d.asn_left == 0) begin
								pl_en = 1'b1; pl_h = n; pl_p = st_d.acc;
							end
						end
						default: begin
							if (st_q.acc != 0) st_d.acc = st_q.acc - 32'd1;
							if (st_d.acc == 0) e_err = 1'b1;
						end
					endcase
				end
				plf_pkg::MODE_GIOP: if (n == 12) begin
					if (h[0] != "G" || h[1] != "I" || h[2] != "O" || h[3] != "P")
						e_err = 1'b1;
					else begin
						pl_en = 1'b1; pl_h = 32'd12;
						pl_p = h[6][0] ? {h[11], h[10], h[9], h[8]}
							: {h[8], h[9], h[10], h[11]};
					end
				end
				plf_pkg::MODE_FCGI: if (n == 8) begin
					if (h[0] != 8'h01) e_err = 1'b1;
					else begin
						pl_en = 1'b1; pl_h = 32'd8;
						pl_p = {16'd0, h[4], h[5]} + {24'd0, h[6]};
					end
				end
				plf_pkg::MODE_LINE: begin
					if (cfg.max_len != 0 && n > cfg.max_len) e_err = 1'b1;
					else if (b == cfg.delim) begin
						e_len = 1'b1;
						e_val = (cfg.cut_len != 0 && n > cfg.cut_len)
							? {1'b0, cfg.cut_len} : {1'b0, n};
					end else if (cfg.cut_len != 0 && n >= cfg.cut_len) begin
						e_len = 1'b1; e_val = {1'b0, cfg.cut_len};
					end
				end
				plf_pkg::MODE_HTTP, plf_pkg::MODE_HTTP_HDR: begin
					st_d.pend = '0;
					if (b == 8'h0a && (n == 1 || (n == 2 && h[0] == 8'h0d))) begin
						e_len = 1'b1; e_val = {1'b0, n};
						st_d.pend = p;
					end else if (p != 0) begin
						if (!((b == 8'h20 || b == 8'h09) && p > 2)) begin
							if (lim != 0 && p > lim) e_err = 1'b1;
							else begin e_len = 1'b1; e_val = {1'b0, p}; end
						end else if (lim != 0 && n >= lim) e_err = 1'b1;
					end else if (b == 8'h0a) begin
						if (lim != 0 && n > lim) e_err = 1'b1;
						else if (!hdr_http) begin e_len = 1'b1; e_val = {1'b0, n}; end
						else st_d.pend = n;
					end else if (lim != 0 && n >= lim) e_err = 1'b1;
				end
				plf_pkg::MODE_TPKT: if (n == 4) begin
					if (h[0] != 8'd3 || {h[2], h[3]} < 16'd4) e_err = 1'b1;
					else begin
						pl_en = 1'b1; pl_h = 32'd4;
						pl_p = {16'd0, h[2], h[3]} - 32'd4;
					end
				end
				plf_pkg::MODE_TLS: if (n == 5) begin
					pl_h = 32'd5;
					if (h[0][7] && h[2] == 8'd1) begin
						if (v16 < 16'd3) e_err = 1'b1;
						else begin pl_en = 1'b1; pl_p = {16'd0, v16} - 32'd3; end
					end else begin
						pl_en = 1'b1; pl_p = {16'd0, h[3], h[4]};
					end
				end
				default: e_err = 1'b1;
			endcase
		end
		pl_sum  = {1'b0, pl_h} + {1'b0, pl_p};
		pl_over = cfg.max_len != 0 && pl_p > cfg.max_len;
		res.emit = e_err || e_len || pl_en;
		res.err  = e_err || (pl_en && (pl_over || pl_sum > {1'b0, plf_pkg::LEN_LIMIT}))
			|| (e_len && e_val > {1'b0, plf_pkg::LEN_LIMIT});
		res.len  = res.err ? 31'd0 : (pl_en ? pl_sum[30:0] : e_val[30:0]);
		if (res.emit) st_d.done = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= plf_pkg::SCAN_IDLE;
		end else if (step && (first || !st_q.done)) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			for (int i = 0; i < plf_pkg::HDR_DEPTH; i++)
				if (n == 32'(i + 1)) hb_q[i] <= b;
		end
	end

endmodule
